>>> design/nlp_pkg.sv
// ----------------------------------------------------------------------------
// nlp_pkg
// Shared types and codes of the next lexicographic permutation engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package nlp_pkg;

   // transaction kinds on the request channel
   localparam logic REQ_LOAD    = 1'b0;
   localparam logic REQ_ADVANCE = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PIV_PRIME,
      ST_PIV_CMP,
      ST_SUCC_CMP,
      ST_SWAP_A,
      ST_SWAP_B,
      ST_REV_RD_LO,
      ST_REV_RD_HI,
      ST_REV_WR_LO,
      ST_REV_WR_HI,
      ST_OUT_FETCH,
      ST_OUT_SEND,
      ST_NO_NEXT
   } state_type;

endpackage

>>> design/nlp_store.sv
// ----------------------------------------------------------------------------
// nlp_store
// Element memory: one write port and one read port with registered data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nlp_store #(
   parameter int DEPTH      = 8,
   parameter int DATA_BITS  = 8,
   parameter int ADDR_BITS  = 3
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [DATA_BITS-1:0] wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [DATA_BITS-1:0] rd_data
);

   logic [DATA_BITS-1:0] mem_ff [DEPTH];
   logic [DATA_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/next_lexicographic_permutation.sv
// ----------------------------------------------------------------------------
// next_lexicographic_permutation
// Loads give no result; busy stays low.
// An advance over n active elements keeps busy high while it scans, swaps,
// reverses and sends its results; its pace is bounded by the element memory
// with its one read and one write port that every scan, swap and output step
// goes through; results are registered.
// Synchronous reset sets active_count to MAX_ELEMENTS; elements are unset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module next_lexicographic_permutation #(
   parameter int MAX_ELEMENTS = 8,
   parameter int ELEMENT_BITS = 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic                                  req_type,
   input  logic [$clog2(MAX_ELEMENTS)-1:0]       req_load_index,
   input  logic [ELEMENT_BITS-1:0]               req_load_value,
   input  logic                                  csr_wr_en,
   input  logic [$clog2(MAX_ELEMENTS+1)-1:0]     csr_wr_data,
   output logic                                  rsp_valid,
   output logic [$clog2(MAX_ELEMENTS)-1:0]       rsp_out_index,
   output logic [ELEMENT_BITS-1:0]               rsp_out_value,
   output logic                                  rsp_has_next,
   output logic                                  rsp_last_item
);

   localparam int IDX_W = $clog2(MAX_ELEMENTS);
   localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ELEMENTS);
   localparam logic [IDX_W:0]   MAX_IDX = (IDX_W + 1)'(MAX_ELEMENTS);

   nlp_pkg::state_type state_ff, state_in;

   logic [CNT_W-1:0]        active_ff;
   logic [IDX_W-1:0]        ptr_ff, ptr_in;
   logic [IDX_W-1:0]        lo_ff, lo_in;
   logic [IDX_W-1:0]        last_ff, last_in;
   logic [IDX_W-1:0]        pivot_idx_ff, pivot_idx_in;
   logic [ELEMENT_BITS-1:0] pivot_val_ff, pivot_val_in;
   logic [ELEMENT_BITS-1:0] held_ff, held_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]        rsp_index_ff, rsp_index_in;
   logic [ELEMENT_BITS-1:0] rsp_value_ff, rsp_value_in;
   logic                    rsp_has_next_ff, rsp_has_next_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic                    wr_en;
   logic [IDX_W-1:0]        wr_addr;
   logic [ELEMENT_BITS-1:0] wr_data;
   logic [IDX_W-1:0]        rd_addr;
   logic [ELEMENT_BITS-1:0] rd_data;

   logic                    accept;
   logic [CNT_W-1:0]        n_eff;
   logic [IDX_W-1:0]        n_last;
   logic                    too_few;
   logic                    load_in_range;
   logic [ELEMENT_BITS-1:0] cmp_lhs;
   logic [ELEMENT_BITS-1:0] cmp_rhs;
   logic                    cmp_less;
   logic                    piv_hit;
   logic                    succ_hit;
   logic                    rev_more_after_swap;
   logic                    rev_more;

   nlp_store #(
      .DEPTH     (MAX_ELEMENTS),
      .DATA_BITS (ELEMENT_BITS),
      .ADDR_BITS (IDX_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign accept        = start && (state_ff == nlp_pkg::ST_IDLE);
   assign n_eff         = (active_ff > MAX_CNT) ? MAX_CNT : active_ff;
   assign n_last        = IDX_W'(n_eff - CNT_W'(1));
   assign too_few       = n_eff < CNT_W'(2);
   assign load_in_range = {1'b0, req_load_index} < MAX_IDX;

   // shared comparator use: pivot scan, successor scan
   assign cmp_lhs  = (state_ff == nlp_pkg::ST_SUCC_CMP) ? pivot_val_ff : rd_data;
   assign cmp_rhs  = (state_ff == nlp_pkg::ST_SUCC_CMP) ? rd_data : held_ff;
   assign cmp_less = cmp_lhs < cmp_rhs;
   assign piv_hit  = cmp_less;
   assign succ_hit = cmp_less;

   // suffix reversal: pairs remain while lo < hi
   assign rev_more_after_swap = ({1'b0, pivot_idx_ff} + (IDX_W + 1)'(1)) < {1'b0, last_ff};
   assign rev_more            = ({1'b0, lo_ff} + (IDX_W + 1)'(2)) < {1'b0, ptr_ff};

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         nlp_pkg::ST_IDLE: begin
            if (accept && (req_type == nlp_pkg::REQ_ADVANCE)) begin
               state_in = too_few ? nlp_pkg::ST_NO_NEXT : nlp_pkg::ST_PIV_PRIME;
            end
         end
         nlp_pkg::ST_PIV_PRIME: state_in = nlp_pkg::ST_PIV_CMP;
         nlp_pkg::ST_PIV_CMP: begin
            if (piv_hit) begin
               state_in = nlp_pkg::ST_SUCC_CMP;
            end else if (ptr_ff == IDX_W'(1)) begin
               state_in = nlp_pkg::ST_NO_NEXT;
            end
         end
         nlp_pkg::ST_SUCC_CMP: begin
            if (succ_hit) begin
               state_in = nlp_pkg::ST_SWAP_A;
            end
         end
         nlp_pkg::ST_SWAP_A: state_in = nlp_pkg::ST_SWAP_B;
         nlp_pkg::ST_SWAP_B: begin
            state_in = rev_more_after_swap ? nlp_pkg::ST_REV_RD_LO : nlp_pkg::ST_OUT_FETCH;
         end
         nlp_pkg::ST_REV_RD_LO: state_in = nlp_pkg::ST_REV_RD_HI;
         nlp_pkg::ST_REV_RD_HI: state_in = nlp_pkg::ST_REV_WR_LO;
         nlp_pkg::ST_REV_WR_LO: state_in = nlp_pkg::ST_REV_WR_HI;
         nlp_pkg::ST_REV_WR_HI: begin
            state_in = rev_more ? nlp_pkg::ST_REV_RD_LO : nlp_pkg::ST_OUT_FETCH;
         end
         nlp_pkg::ST_OUT_FETCH: state_in = nlp_pkg::ST_OUT_SEND;
         nlp_pkg::ST_OUT_SEND: begin
            if (ptr_ff == last_ff) begin
               state_in = nlp_pkg::ST_IDLE;
            end
         end
         nlp_pkg::ST_NO_NEXT: state_in = nlp_pkg::ST_IDLE;
         default: state_in = nlp_pkg::ST_IDLE;
      endcase
   end

   // outputs and datapath controls
   always_comb begin
      busy            = 1'b1;
      rd_addr         = ptr_ff;
      wr_en           = 1'b0;
      wr_addr         = ptr_ff;
      wr_data         = held_ff;
      ptr_in          = ptr_ff;
      lo_in           = lo_ff;
      last_in         = last_ff;
      pivot_idx_in    = pivot_idx_ff;
      pivot_val_in    = pivot_val_ff;
      held_in         = held_ff;
      rsp_valid_in    = 1'b0;
      rsp_index_in    = rsp_index_ff;
      rsp_value_in    = rsp_value_ff;
      rsp_has_next_in = rsp_has_next_ff;
      rsp_last_in     = rsp_last_ff;
      unique case (state_ff)
         nlp_pkg::ST_IDLE: begin
            busy    = 1'b0;
            rd_addr = n_last;
            if (accept) begin
               if (req_type == nlp_pkg::REQ_LOAD) begin
                  wr_en   = load_in_range;
                  wr_addr = req_load_index;
                  wr_data = req_load_value;
               end else begin
                  ptr_in  = n_last;
                  last_in = n_last;
               end
            end
         end
         nlp_pkg::ST_PIV_PRIME: begin
            held_in = rd_data;
            rd_addr = ptr_ff - IDX_W'(1);
         end
         nlp_pkg::ST_PIV_CMP: begin
            if (piv_hit) begin
               pivot_idx_in = ptr_ff - IDX_W'(1);
               pivot_val_in = rd_data;
               ptr_in       = last_ff;
               rd_addr      = last_ff;
            end else begin
               held_in = rd_data;
               ptr_in  = ptr_ff - IDX_W'(1);
               rd_addr = ptr_ff - IDX_W'(2);
            end
         end
         nlp_pkg::ST_SUCC_CMP: begin
            if (succ_hit) begin
               held_in = rd_data;
            end else begin
               ptr_in  = ptr_ff - IDX_W'(1);
               rd_addr = ptr_ff - IDX_W'(1);
            end
         end
         nlp_pkg::ST_SWAP_A: begin
            wr_en   = 1'b1;
            wr_addr = pivot_idx_ff;
            wr_data = held_ff;
         end
         nlp_pkg::ST_SWAP_B: begin
            wr_en   = 1'b1;
            wr_addr = ptr_ff;
            wr_data = pivot_val_ff;
            lo_in   = pivot_idx_ff + IDX_W'(1);
            ptr_in  = last_ff;
         end
         nlp_pkg::ST_REV_RD_LO: begin
            rd_addr = lo_ff;
         end
         nlp_pkg::ST_REV_RD_HI: begin
            rd_addr = ptr_ff;
            held_in = rd_data;
         end
         nlp_pkg::ST_REV_WR_LO: begin
            wr_en   = 1'b1;
            wr_addr = lo_ff;
            wr_data = rd_data;
         end
         nlp_pkg::ST_REV_WR_HI: begin
            wr_en   = 1'b1;
            wr_addr = ptr_ff;
            wr_data = held_ff;
            lo_in   = lo_ff + IDX_W'(1);
            ptr_in  = ptr_ff - IDX_W'(1);
         end
         nlp_pkg::ST_OUT_FETCH: begin
            rd_addr = '0;
            ptr_in  = '0;
         end
         nlp_pkg::ST_OUT_SEND: begin
            rsp_valid_in    = 1'b1;
            rsp_index_in    = ptr_ff;
            rsp_value_in    = rd_data;
            rsp_has_next_in = 1'b1;
            rsp_last_in     = (ptr_ff == last_ff);
            rd_addr         = ptr_ff + IDX_W'(1);
            ptr_in          = ptr_ff + IDX_W'(1);
         end
         nlp_pkg::ST_NO_NEXT: begin
            rsp_valid_in    = 1'b1;
            rsp_index_in    = '0;
            rsp_value_in    = '0;
            rsp_has_next_in = 1'b0;
            rsp_last_in     = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= nlp_pkg::ST_IDLE;
         active_ff    <= MAX_CNT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            active_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff          <= ptr_in;
      lo_ff           <= lo_in;
      last_ff         <= last_in;
      pivot_idx_ff    <= pivot_idx_in;
      pivot_val_ff    <= pivot_val_in;
      held_ff         <= held_in;
      rsp_index_ff    <= rsp_index_in;
      rsp_value_ff    <= rsp_value_in;
      rsp_has_next_ff <= rsp_has_next_in;
      rsp_last_ff     <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_index = rsp_index_ff;
   assign rsp_out_value = rsp_value_ff;
   assign rsp_has_next  = rsp_has_next_ff;
   assign rsp_last_item = rsp_last_ff;

endmodule

>>> design/nlp_checker.sv
// ----------------------------------------------------------------------------
// nlp_checker
// Port-level checks of the permutation engine, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nlp_checker #(
   parameter int MAX_ELEMENTS = 8,
   parameter int ELEMENT_BITS = 8
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              start,
   input logic                              busy,
   input logic                              req_type,
   input logic                              rsp_valid,
   input logic [$clog2(MAX_ELEMENTS)-1:0]   rsp_out_index,
   input logic [ELEMENT_BITS-1:0]           rsp_out_value,
   input logic                              rsp_has_next,
   input logic                              rsp_last_item
);

   localparam int IDX_W = $clog2(MAX_ELEMENTS);

   // an exhausted advance gives a single zeroed final transaction
   a_no_next_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_has_next |->
         rsp_last_item && (rsp_out_index == '0) && (rsp_out_value == '0))
      else $error("no-next result malformed");

   // a stream that is not finished continues with the next index
   a_stream_contiguous: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_item |=>
         rsp_valid && rsp_has_next &&
         (rsp_out_index == $past(rsp_out_index) + IDX_W'(1)))
      else $error("result stream broken");

   // a stream always begins at index zero
   a_stream_starts_at_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_has_next && !$past(rsp_valid) |-> rsp_out_index == '0)
      else $error("result stream does not start at index zero");

   // loads finish at once and give nothing back
   a_load_quiet: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_type == nlp_pkg::REQ_LOAD) |=> !busy && !rsp_valid)
      else $error("load transaction not completed in one cycle");

endmodule

bind next_lexicographic_permutation nlp_checker #(
   .MAX_ELEMENTS (MAX_ELEMENTS),
   .ELEMENT_BITS (ELEMENT_BITS)
) u_nlp_checker (.*);

>>> tb/next_lexicographic_permutation_tb.sv
// ----------------------------------------------------------------------------
// next_lexicographic_permutation_tb
// Drives load and advance transactions into the permutation engine and keeps
// its own copy of the element array to work out each expected stream. Every
// result is checked field by field as it leaves the block. Directed tests
// cover the extremes and corner cases, then random phases run under changing
// active counts and sender idling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module next_lexicographic_permutation_tb;

   localparam int ELEMENTS    = 8;
   localparam int STALL_LIMIT = 4000;
   localparam int SETTLE      = 50;

   typedef struct packed {
      logic [2:0] elem_index;
      logic [7:0] elem_value;
      logic       has_next;
      logic       last_item;
   } perm_result_type;

   logic       clock = 1'b0;
   logic       reset;
   logic       start;
   logic       busy;
   logic       req_type;
   logic [2:0] req_load_index;
   logic [7:0] req_load_value;
   logic       csr_wr_en;
   logic [3:0] csr_wr_data;
   logic       rsp_valid;
   logic [2:0] rsp_out_index;
   logic [7:0] rsp_out_value;
   logic       rsp_has_next;
   logic       rsp_last_item;

   // mirror of the block state
   logic [7:0]      element_mirror [ELEMENTS];
   logic [3:0]      active_count_mirror;
   perm_result_type perm_results_due [$];

   int mismatch_count  = 0;
   int items_sent      = 0;
   int sender_idle_pct = 0;
   int stall_cycles    = 0;

   next_lexicographic_permutation #(
      .MAX_ELEMENTS(ELEMENTS),
      .ELEMENT_BITS(8)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_type       (req_type),
      .req_load_index (req_load_index),
      .req_load_value (req_load_value),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .rsp_valid      (rsp_valid),
      .rsp_out_index  (rsp_out_index),
      .rsp_out_value  (rsp_out_value),
      .rsp_has_next   (rsp_has_next),
      .rsp_last_item  (rsp_last_item)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void predict_next_permutation();
      int n, p, s, lo, hi;
      logic [7:0] t;
      perm_result_type r;
      n = (active_count_mirror > ELEMENTS) ? ELEMENTS : int'(active_count_mirror);
      p = 0;
      if (n >= 2) begin
         p = n - 1;
         while (p > 0 && !(element_mirror[p-1] < element_mirror[p])) p--;
      end
      if (p == 0) begin
         r.elem_index = 3'd0;
         r.elem_value = 8'd0;
         r.has_next   = 1'b0;
         r.last_item  = 1'b1;
         perm_results_due.push_back(r);
         return;
      end
      // pivot at p-1, swap with rightmost strictly greater element
      s = n - 1;
      while (!(element_mirror[p-1] < element_mirror[s])) s--;
      t = element_mirror[p-1];
      element_mirror[p-1] = element_mirror[s];
      element_mirror[s] = t;
      lo = p;
      hi = n - 1;
      while (lo < hi) begin
         t = element_mirror[lo];
         element_mirror[lo] = element_mirror[hi];
         element_mirror[hi] = t;
         lo++;
         hi--;
      end
      for (int k = 0; k < n; k++) begin
         r.elem_index = k[2:0];
         r.elem_value = element_mirror[k];
         r.has_next   = 1'b1;
         r.last_item  = (k == n - 1);
         perm_results_due.push_back(r);
      end
   endfunction

   // one transaction on the request channel; start stays high if no idle follows
   task automatic send_request(input logic kind, input logic [2:0] idx,
                               input logic [7:0] val);
      while ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start          <= 1'b1;
      req_type       <= kind;
      req_load_index <= idx;
      req_load_value <= val;
      do @(posedge clock); while (busy);
      items_sent++;
      if (kind == nlp_pkg::REQ_LOAD)
         element_mirror[idx] = val;
      else
         predict_next_permutation();
   endtask

   task automatic drain_results();
      start <= 1'b0;
      while (perm_results_due.size() != 0 || busy) @(posedge clock);
   endtask

   task automatic write_active_count(input logic [3:0] count);
      drain_results();
      // loads give no result, so let the block settle before touching the register
      repeat (SETTLE) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= count;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      active_count_mirror = count;
   endtask

   task automatic advance();
      send_request(nlp_pkg::REQ_ADVANCE, 3'($urandom_range(7)), 8'($urandom_range(255)));
   endtask

   task automatic test_full_array();
      logic [7:0] vals [ELEMENTS] = '{8'd0, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 8'd255};
      for (int i = 0; i < ELEMENTS; i++) send_request(nlp_pkg::REQ_LOAD, i[2:0], vals[i]);
      advance();
      advance();
   endtask

   task automatic test_last_permutation();
      write_active_count(4'd3);
      send_request(nlp_pkg::REQ_LOAD, 3'd0, 8'd200);
      send_request(nlp_pkg::REQ_LOAD, 3'd1, 8'd100);
      send_request(nlp_pkg::REQ_LOAD, 3'd2, 8'd100);
      advance();
   endtask

   task automatic test_duplicate_values();
      // 200 100 200 -> 200 200 100, then descending with ties
      send_request(nlp_pkg::REQ_LOAD, 3'd2, 8'd200);
      advance();
      advance();
   endtask

   task automatic test_short_counts();
      write_active_count(4'd0);
      advance();
      write_active_count(4'd1);
      advance();
      write_active_count(4'd2);
      advance();
   endtask

   task automatic test_large_count();
      write_active_count(4'd15);
      advance();
   endtask

   task automatic test_random_phase(input int idle_pct, input int item_target);
      int first_item, mode, span, reps;
      sender_idle_pct = idle_pct;
      first_item = items_sent;
      while (items_sent - first_item < item_target) begin
         mode = $urandom_range(99);
         if (mode < 12) begin
            if ($urandom_range(99) < 15)
               write_active_count(4'($urandom_range(15, 9)));
            else
               write_active_count(4'($urandom_range(8, 0)));
         end else if (mode < 17) begin
            drain_results();
         end else if (mode < 72) begin
            // fresh array, then a run of advances
            case ($urandom_range(2))
               0:       span = 3;
               1:       span = 15;
               default: span = 255;
            endcase
            for (int i = 0; i < ELEMENTS; i++)
               send_request(nlp_pkg::REQ_LOAD, i[2:0], 8'($urandom_range(span)));
            reps = $urandom_range(10, 1);
            repeat (reps) advance();
         end else if (mode < 86) begin
            repeat (5) begin
               if ($urandom_range(1))
                  advance();
               else
                  send_request(nlp_pkg::REQ_LOAD, 3'($urandom_range(7)),
                               8'($urandom_range(255)));
            end
         end else begin
            // partial reload in the middle of a sequence
            reps = $urandom_range(3, 1);
            repeat (reps)
               send_request(nlp_pkg::REQ_LOAD, 3'($urandom_range(7)), 8'($urandom_range(7)));
            reps = $urandom_range(4, 1);
            repeat (reps) advance();
         end
      end
   endtask

   // result checking
   always @(posedge clock) begin
      perm_result_type want;
      if (!reset && rsp_valid) begin
         if (perm_results_due.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result: idx %0d val %0d next %b last %b",
                        rsp_out_index, rsp_out_value, rsp_has_next, rsp_last_item);
         end else begin
            want = perm_results_due.pop_front();
            if (rsp_out_index !== want.elem_index || rsp_out_value !== want.elem_value ||
                rsp_has_next !== want.has_next || rsp_last_item !== want.last_item) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: exp %0d/%0d/%b/%b got %0d/%0d/%b/%b",
                           want.elem_index, want.elem_value, want.has_next, want.last_item,
                           rsp_out_index, rsp_out_value, rsp_has_next, rsp_last_item);
            end
         end
      end
   end

   // watchdog on cycles with no transaction of any kind
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || csr_wr_en)
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      reset          <= 1'b1;
      start          <= 1'b0;
      req_type       <= nlp_pkg::REQ_LOAD;
      req_load_index <= '0;
      req_load_value <= '0;
      csr_wr_en      <= 1'b0;
      csr_wr_data    <= '0;
      active_count_mirror = 4'd8;
      for (int i = 0; i < ELEMENTS; i++) element_mirror[i] = 8'd0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      sender_idle_pct = 27;
      test_full_array();
      test_last_permutation();
      test_duplicate_values();
      test_short_counts();
      test_large_count();
      write_active_count(4'd8);

      test_random_phase(27, 125);
      test_random_phase(77, 125);
      test_random_phase(0, 125);

      drain_results();
      repeat (SETTLE) @(posedge clock);
      if (mismatch_count == 0 && perm_results_due.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
